// File: rtl/rpn_pkg.sv
// Package for the reverse Polish calculator: opcodes, payload structs,
// and the controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;

    localparam int unsigned DefStackDepth = 64;
    localparam int unsigned DivSteps      = 48;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_MOD   = 3'd5,
        OP_PRINT = 3'd6,
        OP_NONE  = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic               printed;
        logic signed [31:0] value;
        logic               underflow;
        logic               overflow;
        logic               zero_divisor;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic pop_b;     // pop into the right operand
        logic pop_a;     // pop into the left operand
        logic mul;       // register the product
        logic div_start; // start the divider
        logic push_res;  // push the computed result
        logic push_in;   // push the input operand
        logic emit;      // latch the zero-divisor flag
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic zdiv;      // right operand is a zero divisor for the opcode
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/rpn_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, for the calculator.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient,
    output logic [31:0] remainder
);
    localparam int unsigned CntW = $clog2(rpn_pkg::DivSteps + 1);

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [47:0]     q_reg, q_next;
    logic [32:0]     r_reg, r_next;
    logic [31:0]     d_reg, d_next;
    logic            busy_reg, busy_next;
    logic [32:0]     shifted;
    logic [32:0]     diff;

    always_comb begin
        shifted   = {r_reg[31:0], q_reg[47]};
        diff      = shifted - {1'b0, d_reg};
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[32]) begin
                r_next = shifted;
                q_next = {q_reg[46:0], 1'b0};
            end else begin
                r_next = diff;
                q_next = {q_reg[46:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(rpn_pkg::DivSteps - 1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_next;
    assign remainder = r_next[31:0];
endmodule

// File: rtl/rpn_datapath.sv
// Datapath of the calculator: the value stack memory, operand registers,
// multiplier and divider. Depends on rpn_pkg and rpn_divider.
`timescale 1ns / 1ps
module rpn_datapath #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::DefStackDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpn_pkg::in_item_t   in_item,
    input  rpn_pkg::cmd_t       cmd,
    output rpn_pkg::sts_t       sts,
    output rpn_pkg::out_item_t  result,
    output logic [2:0]          op
);
    localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] mem [STACK_DEPTH];
    logic [CntW-1:0]    count_reg, count_next;
    logic [2:0]         op_reg;
    logic signed [31:0] operand_reg;
    logic signed [31:0] a_reg, b_reg, res_reg, res_next;
    logic signed [31:0] rd_reg;
    logic signed [31:0] rd_data;
    logic               under_reg, over_reg, zdiv_reg;
    logic signed [63:0] prod_reg;
    logic               empty, full;
    logic [AddrW-1:0]   rd_addr;
    logic               div_done;
    logic [47:0]        div_q;
    logic [31:0]        div_r;
    logic [47:0]        dvd;
    logic [31:0]        dvs;
    logic               neg_q, neg_r;
    logic signed [32:0] a_bias, b_bias;
    logic signed [31:0] a_int, b_int;
    logic signed [49:0] q_signed;
    logic signed [31:0] r_trunc, r_adj;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(STACK_DEPTH));
    assign rd_addr = AddrW'(count_reg - 1'b1);
    // The top entry is read into a register every cycle; the count never changes
    // in the state just before a pop, so the registered word is always current.
    assign rd_data = empty ? 32'sd0 : rd_reg;

    // Truncated integers for modulo. Negative values are biased by one less
    // than 1.0 before the shift so that the shift rounds toward zero.
    assign a_bias = 33'(a_reg) + (a_reg[31] ? 33'sd65535 : 33'sd0);
    assign b_bias = 33'(b_reg) + (b_reg[31] ? 33'sd65535 : 33'sd0);
    assign a_int  = 32'(a_bias >>> 16);
    assign b_int  = 32'(b_bias >>> 16);

    always_comb begin
        if (op_reg == rpn_pkg::OP_MOD) begin
            dvd   = 48'(a_int[31] ? -a_int : a_int);
            dvs   = b_int[31] ? 32'(-b_int) : 32'(b_int);
            neg_r = a_int[31];
        end else begin
            dvd   = {(a_reg[31] ? 32'(-a_reg) : 32'(a_reg)), 16'd0};
            dvs   = b_reg[31] ? 32'(-b_reg) : 32'(b_reg);
            neg_r = a_reg[31];
        end
        neg_q = a_reg[31] ^ b_reg[31];
    end

    rpn_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        q_signed = neg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        r_trunc  = neg_r ? -$signed(div_r) : $signed(div_r);
        r_adj    = r_trunc;
        if ((r_trunc < 0 && b_int > 0) || (r_trunc > 0 && b_int < 0)) begin
            r_adj = r_trunc + b_int;
        end
        res_next = res_reg;
        if (div_done) begin
            if (op_reg == rpn_pkg::OP_MOD) res_next = r_adj <<< 16;
            else res_next = rpn_pkg::sat32(66'(q_signed));
        end else if (cmd.mul) begin
            res_next = 32'sd0;
        end
        unique case (op_reg)
            rpn_pkg::OP_ADD: sts.zdiv = 1'b0;
            rpn_pkg::OP_DIV: sts.zdiv = (b_reg == 32'sd0);
            rpn_pkg::OP_MOD: sts.zdiv = (b_int == 32'sd0);
            default:         sts.zdiv = 1'b0;
        endcase
        sts.div_done = div_done;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.pop_a || cmd.pop_b) begin
            if (!empty) count_next = count_reg - 1'b1;
        end else if (cmd.push_res || cmd.push_in) begin
            if (!full) count_next = count_reg + 1'b1;
        end
    end

    logic signed [31:0] final_res;
    always_comb begin
        case (op_reg)
            rpn_pkg::OP_ADD: final_res = rpn_pkg::sat32(66'(a_reg) + 66'(b_reg));
            rpn_pkg::OP_SUB: final_res = rpn_pkg::sat32(66'(a_reg) - 66'(b_reg));
            rpn_pkg::OP_MUL: final_res = rpn_pkg::sat32(66'(prod_reg >>> 16));
            default:         final_res = res_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        rd_reg <= mem[rd_addr];
        if (cmd.load) begin
            op_reg      <= in_item.opcode;
            operand_reg <= in_item.operand_value;
            under_reg   <= 1'b0;
            over_reg    <= 1'b0;
            zdiv_reg    <= 1'b0;
            a_reg       <= 32'sd0;
            b_reg       <= 32'sd0;
        end
        if (cmd.pop_b) begin
            b_reg <= rd_data;
            if (empty) under_reg <= 1'b1;
        end
        if (cmd.pop_a) begin
            a_reg <= rd_data;
            if (empty) under_reg <= 1'b1;
        end
        if (cmd.mul) prod_reg <= 64'(a_reg) * 64'(b_reg);
        res_reg <= res_next;
        if (cmd.push_res || cmd.push_in) begin
            if (full) begin
                over_reg <= 1'b1;
            end else begin
                mem[AddrW'(count_reg)] <= cmd.push_in ? operand_reg : final_res;
            end
        end
        if (cmd.emit && sts.zdiv) zdiv_reg <= 1'b1;
    end

    assign op                  = op_reg;
    assign result.printed      = (op_reg == rpn_pkg::OP_PRINT);
    assign result.value        = (op_reg == rpn_pkg::OP_PRINT) ? b_reg : 32'sd0;
    assign result.underflow    = under_reg;
    assign result.overflow     = over_reg;
    assign result.zero_divisor = zdiv_reg;
endmodule

// File: rtl/rpn_controller.sv
// Sequencing state machine of the calculator: handshakes and datapath
// commands. Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  logic [2:0]    op,
    input  rpn_pkg::sts_t sts,
    output rpn_pkg::cmd_t cmd
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_POPB  = 9'b000000010,
        ST_CHKZ  = 9'b000000100,
        ST_POPA  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_PUSH  = 9'b001000000,
        ST_FLAG  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A new transaction is taken in idle even while the previous result waits
    // in the output register; the output step holds until the slot frees.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_POPB;
                end
            end
            ST_POPB: begin
                if (op == rpn_pkg::OP_PUSH) begin
                    cmd.push_in = 1'b1;
                    state_next  = ST_OUT;
                end else if (op == rpn_pkg::OP_NONE) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.pop_b  = 1'b1;
                    state_next = (op == rpn_pkg::OP_PRINT) ? ST_OUT : ST_CHKZ;
                end
            end
            ST_CHKZ: begin
                if (sts.zdiv) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_POPA;
                end
            end
            ST_POPA: begin
                cmd.pop_a = 1'b1;
                state_next = (op == rpn_pkg::OP_MUL) ? ST_MUL
                           : (op == rpn_pkg::OP_DIV || op == rpn_pkg::OP_MOD) ? ST_FLAG
                           : ST_PUSH;
            end
            ST_FLAG: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PUSH;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                cmd.push_res = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: rtl/rpn_stack_calculator.sv
// Top level of the reverse Polish calculator: output register plus
// controller and datapath. Depends on rpn_pkg, rpn_controller, rpn_datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_valid/s_ready/s_item carries one token per transaction:
//   push, add, subtract, multiply, divide, modulo or print, in Q16.16.
//   Result channel m_valid/m_ready/m_item returns exactly one item per token.
//   Divide and modulo run on the 48-step bit-serial divider. One token is
//   in work at a time, so a token is taken only after the token before it
//   has left its output step.
//   The result sits in an output register; the next token is taken while
//   it waits, and the block holds in its last step if the receiver stalls.
//   Reset (aresetn low, synchronous) empties the stack and drops any
//   pending result; stack memory contents are not cleared.
module rpn_stack_calculator #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::DefStackDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpn_pkg::out_item_t m_item
);
    rpn_pkg::cmd_t      cmd;
    rpn_pkg::sts_t      sts;
    rpn_pkg::out_item_t res;
    rpn_pkg::out_item_t out_reg;
    logic [2:0]         op;
    logic               u_ctrl_load_out;

    rpn_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .op(op), .sts(sts), .cmd(cmd)
    );

    rpn_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_item), .cmd(cmd),
        .sts(sts), .result(res), .op(op)
    );

    assign u_ctrl_load_out = !m_valid || m_ready;

    // Load whenever the output slot is free, so the result is captured as the controller raises valid.
    always_ff @(posedge aclk) begin
        if (u_ctrl_load_out) out_reg <= res;
    end

    assign m_item = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second transaction immediately");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop_a || cmd.pop_b) |-> !(cmd.push_in || cmd.push_res))
        else $error("pop and push in the same cycle");
endmodule

// File: verif/rpn_result_checker.sv
// Result checker for the reverse Polish calculator: watches both channels,
// predicts each result from the accepted tokens and compares. Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_result_checker #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::DefStackDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  rpn_pkg::out_item_t m_item,
    output int                 mismatches,
    output int                 pending,
    output int                 results_seen,
    output int                 prints_seen,
    output int                 flags_seen
);
    logic signed [31:0] calc_stack [STACK_DEPTH];
    int unsigned        depth_now;
    rpn_pkg::out_item_t expected_results [$];
    logic               under_hit;
    logic               over_hit;

    assign pending = expected_results.size();

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -128'sd2147483648) r = 32'sh8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] take_top();
        logic signed [31:0] v;
        if (depth_now == 0) begin
            under_hit = 1'b1;
            v = '0;
        end else begin
            depth_now--;
            v = calc_stack[depth_now];
        end
        return v;
    endfunction

    function automatic void put_top(input logic signed [31:0] v);
        if (depth_now >= STACK_DEPTH) begin
            over_hit = 1'b1;
        end else begin
            calc_stack[depth_now] = v;
            depth_now++;
        end
    endfunction

    function automatic rpn_pkg::out_item_t evaluate_token(input rpn_pkg::in_item_t tok);
        rpn_pkg::out_item_t  res;
        logic signed [31:0]  a, b;
        logic signed [127:0] p, n, d, r;
        res = '0;
        under_hit = 1'b0;
        over_hit = 1'b0;
        case (rpn_pkg::opcode_t'(tok.opcode))
            rpn_pkg::OP_PUSH: put_top(tok.operand_value);
            rpn_pkg::OP_ADD: begin
                b = take_top();
                a = take_top();
                put_top(clamp32(128'(a) + 128'(b)));
            end
            rpn_pkg::OP_SUB: begin
                b = take_top();
                a = take_top();
                put_top(clamp32(128'(a) - 128'(b)));
            end
            rpn_pkg::OP_MUL: begin
                b = take_top();
                a = take_top();
                p = 128'(a) * 128'(b);
                put_top(clamp32(p >>> 16)); // arithmetic shift floors
            end
            rpn_pkg::OP_DIV: begin
                b = take_top();
                if (b == 0) begin
                    res.zero_divisor = 1'b1;
                end else begin
                    a = take_top();
                    put_top(clamp32((128'(a) * 65536) / 128'(b)));
                end
            end
            rpn_pkg::OP_MOD: begin
                b = take_top();
                d = 128'(b) / 65536;
                if (d == 0) begin
                    res.zero_divisor = 1'b1;
                end else begin
                    a = take_top();
                    n = 128'(a) / 65536;
                    r = n % d;
                    if ((r < 0 && d > 0) || (r > 0 && d < 0)) r = r + d;
                    put_top(clamp32(r * 65536));
                end
            end
            rpn_pkg::OP_PRINT: begin
                res.printed = 1'b1;
                res.value = take_top();
            end
            default: ;
        endcase
        res.underflow = under_hit;
        res.overflow = over_hit;
        return res;
    endfunction

    always @(posedge aclk) begin
        rpn_pkg::out_item_t want;
        if (!aresetn) begin
            depth_now = 0;
            expected_results.delete();
            mismatches <= 0;
            results_seen <= 0;
            prints_seen <= 0;
            flags_seen <= 0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(evaluate_token(s_item));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_item.printed) prints_seen <= prints_seen + 1;
                if (m_item.underflow || m_item.overflow || m_item.zero_divisor)
                    flags_seen <= flags_seen + 1;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) $display("Unexpected result transaction: %p", m_item);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item !== want) begin
                        if (mismatches < 10)
                            $display("Mismatch: expected %p, got %p", want, m_item);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// File: verif/tb_rpn_stack_calculator.sv
// Testbench top for the reverse Polish calculator: drives tokens with random
// gaps and gives the verdict. Depends on rpn_pkg, the block and rpn_result_checker.
`timescale 1ns / 1ps
module tb_rpn_stack_calculator;
    localparam int unsigned DEPTH = rpn_pkg::DefStackDepth;
    localparam int unsigned IDLE_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rpn_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rpn_pkg::out_item_t m_item;
    int                 mismatches, pending, results_seen, prints_seen, flags_seen;
    int                 idle_cycles = 0;
    int                 model_depth = 0;
    int                 stall_left = 0;
    logic               stall_drain = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) dut (.*);

    rpn_result_checker #(.STACK_DEPTH(DEPTH)) u_checker (.*);

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Receiver: mostly short stalls, now and then a long one.
    always @(posedge aclk) begin
        int g;
        if (!aresetn || stall_drain) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                stall_left <= g - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_token(input rpn_pkg::opcode_t op, input logic signed [31:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{opcode: op, operand_value: v};
        do @(posedge aclk); while (!s_ready);
        // Rough depth tracking only steers the stimulus shape.
        case (op)
            rpn_pkg::OP_PUSH: if (model_depth < DEPTH) model_depth++;
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
            rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: if (model_depth > 0) model_depth--;
            rpn_pkg::OP_PRINT: if (model_depth > 0) model_depth--;
            default: ;
        endcase
    endtask

    // Stop sending and hold off until every expected result is back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 20)) - 10) <<< 16;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            3: return 32'($urandom_range(0, 131071)) - 32'sd65536;
            default: return (32'($urandom_range(0, 400)) - 32'sd200) <<< 12;
        endcase
    endfunction

    initial begin
        int k;
        rpn_pkg::opcode_t op;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pops, extremes, saturation, zero divisors, unknown code.
        send_token(rpn_pkg::OP_PRINT, 0);
        send_token(rpn_pkg::OP_ADD, 0);
        send_token(rpn_pkg::OP_DIV, 0);
        send_token(rpn_pkg::OP_MOD, 0);
        send_token(rpn_pkg::OP_NONE, 32'sh7FFF_FFFF);
        send_token(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_token(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_token(rpn_pkg::OP_ADD, 0);
        send_token(rpn_pkg::OP_PUSH, 32'sh8000_0000);
        send_token(rpn_pkg::OP_SUB, 0);
        send_token(rpn_pkg::OP_PUSH, -32'sd3 <<< 16);
        send_token(rpn_pkg::OP_MUL, 0);
        send_token(rpn_pkg::OP_PUSH, 32'sh0000_8000);
        send_token(rpn_pkg::OP_MOD, 0);
        send_token(rpn_pkg::OP_PUSH, -32'sd7 <<< 16);
        send_token(rpn_pkg::OP_PUSH, 32'sd2 <<< 16);
        send_token(rpn_pkg::OP_MOD, 0);
        send_token(rpn_pkg::OP_PUSH, 32'sd0);
        send_token(rpn_pkg::OP_DIV, 0);
        send_token(rpn_pkg::OP_PUSH, -32'sd1);
        send_token(rpn_pkg::OP_DIV, 0);
        send_token(rpn_pkg::OP_PRINT, 0);
        send_token(rpn_pkg::OP_PRINT, 0);
        send_token(rpn_pkg::OP_PRINT, 0);

        // Fill past the top to reach the full-stack case.
        for (k = 0; k < DEPTH + 3; k++) send_token(rpn_pkg::OP_PUSH, rand_value());

        // Hold off until every result is back.
        stall_drain <= 1'b1;
        pause_until_drained();
        stall_drain <= 1'b0;

        for (k = 0; k < 1800; k++) begin
            if (k % 600 == 599) begin
                pause_until_drained();
            end
            if ($urandom_range(0, 99) < 4) begin
                op = rpn_pkg::opcode_t'($urandom_range(0, 7));
            end else if (model_depth < 2 ||
                         ($urandom_range(0, 99) < 35 && model_depth < DEPTH - 4)) begin
                op = rpn_pkg::OP_PUSH;
            end else begin
                op = rpn_pkg::opcode_t'($urandom_range(1, 6));
            end
            send_token(op, rand_value());
        end

        pause_until_drained();
        repeat (80) @(posedge aclk);
        $display("Run covered %0d results, %0d prints and %0d flagged results.",
                 results_seen, prints_seen, flags_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
